/* rtl/core/mfi_pkg.sv */
package mfi_pkg;

  localparam int INDEX_BITS_DEF = 24;
  localparam int COORD_W = 32;
  localparam int IDXF_W = 24;
  localparam int NORM_W = 16;
  localparam int IN_W = 360;
  localparam int OUT_W = 224;
  localparam int CFG_W = 32;
  localparam int CFG_IDX_W = 1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_INSET = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START = 1'd1;

  // datapath operations
  localparam logic [4:0] OP_NONE      = 5'd0;
  localparam logic [4:0] OP_LOAD      = 5'd1;
  localparam logic [4:0] OP_EDGE      = 5'd2;
  localparam logic [4:0] OP_XMUL      = 5'd3;
  localparam logic [4:0] OP_XACC      = 5'd4;
  localparam logic [4:0] OP_NCROSS    = 5'd5;
  localparam logic [4:0] OP_NDIR      = 5'd6;
  localparam logic [4:0] OP_SHR       = 5'd7;
  localparam logic [4:0] OP_SHL       = 5'd8;
  localparam logic [4:0] OP_QZERO     = 5'd9;
  localparam logic [4:0] OP_SQMUL     = 5'd10;
  localparam logic [4:0] OP_SQACC     = 5'd11;
  localparam logic [4:0] OP_SQRT_INIT = 5'd12;
  localparam logic [4:0] OP_SQRT_STEP = 5'd13;
  localparam logic [4:0] OP_LEN       = 5'd14;
  localparam logic [4:0] OP_DIV_INIT  = 5'd15;
  localparam logic [4:0] OP_DIV_STEP  = 5'd16;
  localparam logic [4:0] OP_DIV_END   = 5'd17;
  localparam logic [4:0] OP_DMUL      = 5'd18;
  localparam logic [4:0] OP_DACC      = 5'd19;
  localparam logic [4:0] OP_EMIT      = 5'd20;

  typedef struct packed {
    logic [4:0] op;
    logic [3:0] sel;   // component, product step or record number
    logic       dir;   // 1: corner direction (F=30), 0: face normal (F=14)
  } cmd_t;

  typedef struct packed {
    logic zero;  // all magnitudes zero
    logic hi;    // largest magnitude >= 2^30
    logic lo;    // largest magnitude nonzero and < 2^29
  } status_t;

endpackage

/* rtl/core/mfi_ctrl.sv */
module mfi_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  mfi_pkg::status_t status,
  output mfi_pkg::cmd_t    cmd
);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_EDGE   = 5'd1;
  localparam logic [4:0] ST_XMUL   = 5'd2;
  localparam logic [4:0] ST_XACC   = 5'd3;
  localparam logic [4:0] ST_NLOADX = 5'd4;
  localparam logic [4:0] ST_NCHK   = 5'd5;
  localparam logic [4:0] ST_SQMUL  = 5'd6;
  localparam logic [4:0] ST_SQACC  = 5'd7;
  localparam logic [4:0] ST_SQI    = 5'd8;
  localparam logic [4:0] ST_SQRT   = 5'd9;
  localparam logic [4:0] ST_LEN    = 5'd10;
  localparam logic [4:0] ST_DINIT  = 5'd11;
  localparam logic [4:0] ST_DSTEP  = 5'd12;
  localparam logic [4:0] ST_DEND   = 5'd13;
  localparam logic [4:0] ST_NRET   = 5'd14;
  localparam logic [4:0] ST_VLOAD  = 5'd15;
  localparam logic [4:0] ST_DMUL   = 5'd16;
  localparam logic [4:0] ST_DACC   = 5'd17;
  localparam logic [4:0] ST_EMIT   = 5'd18;

  logic [4:0] state, state_next;
  logic [2:0] k, k_next;
  logic [4:0] cnt, cnt_next;
  logic [1:0] v, v_next;
  logic [3:0] rec, rec_next;
  logic       dirm, dirm_next;
  logic       valid, valid_next;
  logic       out_free;

  assign out_free = !valid || m_tready;
  assign m_tvalid = valid;
  assign s_tready = (state == ST_IDLE);

  always_comb begin
    state_next = state;
    k_next = k;
    cnt_next = cnt;
    v_next = v;
    rec_next = rec;
    dirm_next = dirm;
    valid_next = valid && !m_tready;
    cmd.op = mfi_pkg::OP_NONE;
    cmd.sel = 4'(k);
    cmd.dir = dirm;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.op = mfi_pkg::OP_LOAD;
          state_next = ST_EDGE;
        end
      end
      ST_EDGE: begin
        cmd.op = mfi_pkg::OP_EDGE;
        k_next = 3'd0;
        state_next = ST_XMUL;
      end
      ST_XMUL: begin
        cmd.op = mfi_pkg::OP_XMUL;
        state_next = ST_XACC;
      end
      ST_XACC: begin
        cmd.op = mfi_pkg::OP_XACC;
        if (k == 3'd5) begin
          dirm_next = 1'b0;
          state_next = ST_NLOADX;
        end else begin
          k_next = k + 3'd1;
          state_next = ST_XMUL;
        end
      end
      ST_NLOADX: begin
        cmd.op = mfi_pkg::OP_NCROSS;
        state_next = ST_NCHK;
      end
      ST_NCHK: begin
        if (status.zero) begin
          cmd.op = mfi_pkg::OP_QZERO;
          state_next = ST_NRET;
        end else if (status.hi) begin
          cmd.op = mfi_pkg::OP_SHR;
        end else if (status.lo) begin
          cmd.op = mfi_pkg::OP_SHL;
        end else begin
          k_next = 3'd0;
          state_next = ST_SQMUL;
        end
      end
      ST_SQMUL: begin
        cmd.op = mfi_pkg::OP_SQMUL;
        state_next = ST_SQACC;
      end
      ST_SQACC: begin
        cmd.op = mfi_pkg::OP_SQACC;
        if (k == 3'd2) begin
          state_next = ST_SQI;
        end else begin
          k_next = k + 3'd1;
          state_next = ST_SQMUL;
        end
      end
      ST_SQI: begin
        cmd.op = mfi_pkg::OP_SQRT_INIT;
        cnt_next = 5'd0;
        state_next = ST_SQRT;
      end
      ST_SQRT: begin
        cmd.op = mfi_pkg::OP_SQRT_STEP;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd31) state_next = ST_LEN;
      end
      ST_LEN: begin
        cmd.op = mfi_pkg::OP_LEN;
        k_next = 3'd0;
        state_next = ST_DINIT;
      end
      ST_DINIT: begin
        cmd.op = mfi_pkg::OP_DIV_INIT;
        cnt_next = 5'd0;
        state_next = ST_DSTEP;
      end
      ST_DSTEP: begin
        cmd.op = mfi_pkg::OP_DIV_STEP;
        cnt_next = cnt + 5'd1;
        if (cnt == 5'd30) state_next = ST_DEND;
      end
      ST_DEND: begin
        cmd.op = mfi_pkg::OP_DIV_END;
        if (k == 3'd2) begin
          state_next = ST_NRET;
        end else begin
          k_next = k + 3'd1;
          state_next = ST_DINIT;
        end
      end
      ST_NRET: begin
        k_next = 3'd0;
        if (!dirm) begin
          dirm_next = 1'b1;
          v_next = 2'd0;
          state_next = ST_VLOAD;
        end else begin
          state_next = ST_DMUL;
        end
      end
      ST_VLOAD: begin
        cmd.op = mfi_pkg::OP_NDIR;
        state_next = ST_NCHK;
      end
      ST_DMUL: begin
        cmd.op = mfi_pkg::OP_DMUL;
        state_next = ST_DACC;
      end
      ST_DACC: begin
        cmd.op = mfi_pkg::OP_DACC;
        if (k == 3'd2) begin
          rec_next = {2'b00, v};
          state_next = ST_EMIT;
        end else begin
          k_next = k + 3'd1;
          state_next = ST_DMUL;
        end
      end
      ST_EMIT: begin
        cmd.sel = rec;
        if (out_free) begin
          cmd.op = mfi_pkg::OP_EMIT;
          valid_next = 1'b1;
          if (rec < 4'd2) begin
            v_next = v + 2'd1;
            state_next = ST_VLOAD;
          end else if (rec == 4'd9) begin
            state_next = ST_IDLE;
          end else begin
            rec_next = rec + 4'd1;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      k <= 3'd0;
      cnt <= 5'd0;
      v <= 2'd0;
      rec <= 4'd0;
      dirm <= 1'b0;
      valid <= 1'b0;
    end else begin
      state <= state_next;
      k <= k_next;
      cnt <= cnt_next;
      v <= v_next;
      rec <= rec_next;
      dirm <= dirm_next;
      valid <= valid_next;
    end
  end

endmodule

/* rtl/core/mfi_datapath.sv */
module mfi_datapath #(
  parameter int INDEX_BITS = mfi_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [mfi_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mfi_pkg::CFG_W-1:0]       cfg_data,
  input  logic [mfi_pkg::IN_W-1:0]        in_data,
  input  mfi_pkg::cmd_t                   cmd,
  output mfi_pkg::status_t                status,
  output logic [mfi_pkg::OUT_W-1:0]       out_data,
  output logic                            out_kind,
  output logic                            out_last
);

  // triangle slots: 0..2 original corners, 3..5 new vertices
  localparam logic [2:0] TRI [7][3] = '{
    '{3'd0, 3'd1, 3'd4}, '{3'd0, 3'd4, 3'd3}, '{3'd1, 3'd2, 3'd5},
    '{3'd1, 3'd5, 3'd4}, '{3'd2, 3'd0, 3'd3}, '{3'd2, 3'd3, 3'd5},
    '{3'd3, 3'd4, 3'd5}};

  logic signed [31:0] p [3][3];       // [corner][axis], corner 0 is the one in work
  logic [INDEX_BITS-1:0] idx [3];
  logic [INDEX_BITS-1:0] base, next_vertex;
  logic                  wrapped;
  logic signed [31:0] inset;
  logic [31:0]        amag;

  logic signed [30:0] e1 [3], e2 [3];
  logic signed [65:0] prod;
  logic signed [32:0] mul_a, mul_b;
  logic signed [62:0] xacc;
  logic signed [62:0] cr [3];
  logic [61:0] m [3];
  logic        neg [3];
  logic [61:0] sumsq;
  logic [63:0] sx, sr, sbit, st;
  logic [31:0] len;
  logic [31:0] rem;
  logic [30:0] dq;
  logic [32:0] trial;
  logic        ge;
  logic [30:0] umag [3];
  logic        uneg [3];
  logic signed [15:0] nrm [3];
  logic signed [31:0] np [3];

  logic [1:0] ksel;
  logic [61:0] or_m;
  logic [32:0] mag1 [3], mag2 [3];
  logic [32:0] or1, or2;
  logic [1:0]  s1, s2;
  logic [32:0] f1 [3], f2 [3];
  logic signed [33:0] vsum [3];
  logic signed [34:0] dv [3];
  logic [34:0] dmag [3];
  logic [62:0] crmag [3];
  logic [29:0] m30;
  logic [61:0] num;
  logic [63:0] rnd;
  logic [32:0] dm;
  logic        dsgn;
  logic signed [34:0] np35;
  logic signed [31:0] np_sat;
  logic [INDEX_BITS:0] nv_sum;
  logic [INDEX_BITS-1:0] cand [6];
  logic [2:0]  tsel;

  assign ksel = cmd.sel[1:0];
  assign amag = inset[31] ? (~inset + 32'd1) : inset;

  assign or_m = m[0] | m[1] | m[2];
  assign status.zero = (or_m == 62'd0);
  assign status.hi = |or_m[61:30];
  assign status.lo = !(|or_m[61:29]) && (or_m != 62'd0);

  // edge vectors, scaled down until below 2^30
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag1[k] = (p[1][k] < p[0][k]) ? 33'(p[0][k]) - 33'(p[1][k])
                                    : 33'(p[1][k]) - 33'(p[0][k]);
      mag2[k] = (p[2][k] < p[0][k]) ? 33'(p[0][k]) - 33'(p[2][k])
                                    : 33'(p[2][k]) - 33'(p[0][k]);
    end
    or1 = mag1[0] | mag1[1] | mag1[2];
    or2 = mag2[0] | mag2[1] | mag2[2];
    s1 = or1[32] ? 2'd3 : (or1[31] ? 2'd2 : (or1[30] ? 2'd1 : 2'd0));
    s2 = or2[32] ? 2'd3 : (or2[31] ? 2'd2 : (or2[30] ? 2'd1 : 2'd0));
    for (int k = 0; k < 3; k++) begin
      f1[k] = mag1[k] >> s1;
      f2[k] = mag2[k] >> s2;
    end
  end

  // corner direction 3*(centroid - corner), and cross magnitudes
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      vsum[k] = 34'(p[0][k]) + 34'(p[1][k]) + 34'(p[2][k]);
      dv[k] = 35'(vsum[k]) - (35'(p[0][k]) <<< 1) - 35'(p[0][k]);
      dmag[k] = dv[k][34] ? 35'(-dv[k]) : 35'(dv[k]);
      crmag[k] = cr[k][62] ? 63'(-cr[k]) : 63'(cr[k]);
    end
  end

  // shared multiplier operands
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.op)
      mfi_pkg::OP_XMUL: begin
        case (cmd.sel)
          4'd0: begin mul_a = 33'(e1[1]); mul_b = 33'(e2[2]); end
          4'd1: begin mul_a = 33'(e1[2]); mul_b = 33'(e2[1]); end
          4'd2: begin mul_a = 33'(e1[2]); mul_b = 33'(e2[0]); end
          4'd3: begin mul_a = 33'(e1[0]); mul_b = 33'(e2[2]); end
          4'd4: begin mul_a = 33'(e1[0]); mul_b = 33'(e2[1]); end
          default: begin mul_a = 33'(e1[1]); mul_b = 33'(e2[0]); end
        endcase
      end
      mfi_pkg::OP_SQMUL: begin
        mul_a = {3'b000, m[ksel][29:0]};
        mul_b = {3'b000, m[ksel][29:0]};
      end
      mfi_pkg::OP_DMUL: begin
        mul_a = {1'b0, amag};
        mul_b = {2'b00, umag[ksel]};
      end
      default: ;
    endcase
  end

  // square root, divide, displacement, counter and index helpers
  always_comb begin
    st = sr + sbit;
    m30 = m[ksel][29:0];
    num = (cmd.dir ? {2'b00, m30, 30'd0} : {18'd0, m30, 14'd0}) + 62'(len >> 1);
    trial = {rem, dq[30]};
    ge = (trial >= {1'b0, len});
    rnd = {1'b0, prod[62:0]} + 64'(32'h2000_0000);
    dm = rnd[62:30];
    dsgn = inset[31] ^ (uneg[ksel] && (umag[ksel] != 31'd0));
    np35 = 35'(p[0][ksel]) + (dsgn ? -35'(dm) : 35'(dm));
    if (np35 > 35'sh0_7FFF_FFFF) np_sat = 32'sh7FFF_FFFF;
    else if (np35 < -35'sh0_8000_0000) np_sat = 32'sh8000_0000;
    else np_sat = np35[31:0];
    nv_sum = {1'b0, next_vertex} + (INDEX_BITS+1)'(3);
    for (int s = 0; s < 3; s++) begin
      cand[s] = idx[s];
      cand[s+3] = base + INDEX_BITS'(s);
    end
    tsel = 3'(cmd.sel - 4'd3);
  end

  // counter, wrap flag and config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      next_vertex <= '0;
      wrapped <= 1'b0;
      inset <= '0;
    end else if (cfg_we) begin
      if (cfg_index == mfi_pkg::REG_INSET) inset <= cfg_data;
      if (cfg_index == mfi_pkg::REG_START) begin
        next_vertex <= INDEX_BITS'(cfg_data[23:0]);
        wrapped <= 1'b0;
      end
    end else if (cmd.op == mfi_pkg::OP_LOAD) begin
      next_vertex <= nv_sum[INDEX_BITS-1:0];
      if (nv_sum[INDEX_BITS]) wrapped <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (cmd.op)
      mfi_pkg::OP_LOAD: begin
        for (int c = 0; c < 3; c++) begin
          for (int k = 0; k < 3; k++) p[c][k] <= in_data[(c*3+k)*32 +: 32];
          idx[c] <= INDEX_BITS'(in_data[288 + c*24 +: 24]);
        end
        base <= next_vertex;
      end
      mfi_pkg::OP_EDGE: begin
        for (int k = 0; k < 3; k++) begin
          e1[k] <= (p[1][k] < p[0][k]) ? -31'(f1[k][29:0]) : 31'(f1[k][29:0]);
          e2[k] <= (p[2][k] < p[0][k]) ? -31'(f2[k][29:0]) : 31'(f2[k][29:0]);
        end
      end
      mfi_pkg::OP_XACC: begin
        if (!cmd.sel[0]) xacc <= prod[62:0];
        else cr[cmd.sel[2:1]] <= xacc - prod[62:0];
      end
      mfi_pkg::OP_NCROSS: begin
        for (int k = 0; k < 3; k++) begin
          m[k] <= crmag[k][61:0];
          neg[k] <= cr[k][62];
        end
      end
      mfi_pkg::OP_NDIR: begin
        for (int k = 0; k < 3; k++) begin
          m[k] <= 62'(dmag[k]);
          neg[k] <= dv[k][34];
        end
      end
      mfi_pkg::OP_SHR: for (int k = 0; k < 3; k++) m[k] <= m[k] >> 1;
      mfi_pkg::OP_SHL: for (int k = 0; k < 3; k++) m[k] <= m[k] << 1;
      mfi_pkg::OP_QZERO: begin
        for (int k = 0; k < 3; k++) begin
          if (cmd.dir) umag[k] <= '0;
          else nrm[k] <= '0;
        end
      end
      mfi_pkg::OP_SQACC: begin
        sumsq <= (cmd.sel == 4'd0 ? 62'd0 : sumsq) + prod[61:0];
      end
      mfi_pkg::OP_SQRT_INIT: begin
        sx <= {2'b00, sumsq};
        sr <= '0;
        sbit <= 64'd1 << 62;
      end
      mfi_pkg::OP_SQRT_STEP: begin
        if (sx >= st) begin
          sx <= sx - st;
          sr <= (sr >> 1) + sbit;
        end else begin
          sr <= sr >> 1;
        end
        sbit <= sbit >> 2;
      end
      mfi_pkg::OP_LEN: len <= sr[31:0];
      mfi_pkg::OP_DIV_INIT: begin
        rem <= 32'(num[61:31]);
        dq <= num[30:0];
      end
      mfi_pkg::OP_DIV_STEP: begin
        rem <= ge ? 32'(trial - {1'b0, len}) : trial[31:0];
        dq <= {dq[29:0], ge};
      end
      mfi_pkg::OP_DIV_END: begin
        if (cmd.dir) begin
          umag[ksel] <= dq;
          uneg[ksel] <= neg[ksel];
        end else begin
          nrm[ksel] <= neg[ksel] ? -16'(dq[15:0]) : 16'(dq[15:0]);
        end
      end
      mfi_pkg::OP_DACC: np[ksel] <= np_sat;
      mfi_pkg::OP_EMIT: begin
        out_last <= (cmd.sel == 4'd9);
        if (cmd.sel < 4'd3) begin
          out_kind <= 1'b0;
          out_data <= {7'd0, wrapped, 72'd0, nrm[2], nrm[1], nrm[0],
                       np[2], np[1], np[0]};
          // rotate corners so the next one sits at position 0
          for (int k = 0; k < 3; k++) begin
            p[0][k] <= p[1][k];
            p[1][k] <= p[2][k];
            p[2][k] <= p[0][k];
          end
        end else begin
          out_kind <= 1'b1;
          out_data <= {7'd0, wrapped,
                       24'(cand[TRI[tsel][2]]), 24'(cand[TRI[tsel][1]]),
                       24'(cand[TRI[tsel][0]]), 48'd0, 96'd0};
        end
      end
      default: ;
    endcase
  end

endmodule

/* rtl/core/mesh_face_inset_top.sv */
// Triangle inset engine.
// Slave stream: one triangle per request on s_tdata (three Q16.16 corners and
// their three mesh vertex indices). Master stream: ten records per triangle,
// the three inset vertices (with the Q2.14 unit face normal), then seven index
// triangles (ring quads, then the inner face); m_tlast marks the tenth.
// m_tuser is the record kind: 0 vertex, 1 index triangle.
// Config port: cfg_we/cfg_index/cfg_data, index 0 inset distance (Q16.16),
// index 1 starting vertex number, which also reloads the counter and clears
// the overflow flag. Write only while the block is idle.
// Flow: one triangle at a time. The run time is set by the four
// normalizations (face normal, three corner directions), each running a
// one-bit-per-cycle square root and a restoring divider for each component
// plus a one-bit-per-cycle scaling shift loop; a zero-length vector skips
// its normalization, so degenerate triangles finish sooner.
// A new request is taken once the tenth record sits in the output register.
// Reset (synchronous, rst high) clears the inset, the counter and the flag,
// and drops m_tvalid. A stalled m_tready holds the current record and the
// engine waits at the next record until the output register frees up.
module mesh_face_inset_top #(
  parameter int INDEX_BITS = mfi_pkg::INDEX_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [mfi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [mfi_pkg::CFG_W-1:0]     cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // ax, ay, az, bx, by, bz, cx, cy, cz (32 each), index_a, index_b, index_c (24 each)
  input  logic [mfi_pkg::IN_W-1:0]      s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // pos_x, pos_y, pos_z (32), norm_x, norm_y, norm_z (16), tri_first,
  // tri_second, tri_third (24), overflow (1), zero pad (7)
  output logic [mfi_pkg::OUT_W-1:0]     m_tdata,
  output logic                          m_tuser,  // kind
  output logic                          m_tlast
);

  mfi_pkg::cmd_t    cmd;
  mfi_pkg::status_t status;

  mfi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  mfi_datapath #(.INDEX_BITS(INDEX_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .status    (status),
    .out_data  (m_tdata),
    .out_kind  (m_tuser),
    .out_last  (m_tlast)
  );

  // a taken triangle drops s_tready in the cycle after it is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken while triangle in work");

  // vertex records are never the last of a triangle
  a_vertex_not_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> !m_tlast)
    else $error("vertex record marked last");

  // index triangle records carry no position
  a_tri_no_pos: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[95:0] == 96'd0)
    else $error("triangle record with position data");

endmodule

/* verif/mesh_face_inset_top_test.sv */
module mesh_face_inset_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam longint unsigned IDX_MASK = 64'hFF_FFFF;
  localparam longint unsigned TOP30 = 64'd1 << 30;
  localparam longint unsigned TOP29 = 64'd1 << 29;
  localparam int MAX_C = 32'h7FFF_FFFF;
  localparam int MIN_C = 32'h8000_0000;
  localparam int ONE = 32'h0001_0000;  // 1.0 in Q16.16
  localparam logic [1:0] SET_NONE = 2'd0;
  localparam logic [1:0] SET_INSET = 2'd1;
  localparam logic [1:0] SET_START = 2'd2;

  // one triangle request
  typedef struct {
    logic [31:0] crd[9];  // ax ay az bx by bz cx cy cz
    logic [23:0] idx[3];
  } tri_t;

  // one output record
  typedef struct {
    logic        kind;
    logic [31:0] pos[3];
    logic [15:0] nrm[3];
    logic [23:0] vix[3];
    logic        ovf;
    logic        last;
  } rec_t;

  // directed row: optional register write first, optional typed normal
  typedef struct {
    logic [1:0]  set_what;
    logic [31:0] set_val;
    tri_t        t;
    bit          known;
    logic [15:0] nrm[3];
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [mfi_pkg::CFG_IDX_W-1:0] cfg_index = mfi_pkg::REG_INSET;
  logic [mfi_pkg::CFG_W-1:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [mfi_pkg::IN_W-1:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [mfi_pkg::OUT_W-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;

  mesh_face_inset_top dut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tuser(m_tuser), .m_tlast(m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // model state
  longint inset_q;
  longint unsigned next_vtx;
  bit wrap_flag;

  rec_t pending_recs[$];  // records still owed by the block
  int errors = 0;
  bit idle_on = 1'b1;     // random gaps on both sides
  bit want_hold = 1'b0;   // ask the receiver for one long stall
  bit hold_done = 1'b0;
  int hold_left = 0;
  row_t rows[$];

  // ---------------------------------------------------------------- predictor

  function automatic longint unsigned mag(longint v);
    return v < 0 ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned max3(longint unsigned m[3]);
    longint unsigned x;
    x = m[0];
    if (m[1] > x) x = m[1];
    if (m[2] > x) x = m[2];
    return x;
  endfunction

  // scale magnitudes down below 2^30, and (if grow) up to at least 2^29
  function automatic void fit_mags(inout longint unsigned m[3], input bit grow);
    longint unsigned mx;
    mx = max3(m);
    while (mx >= TOP30) begin
      for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
      mx = mx >> 1;
    end
    if (grow && mx != 0)
      while (mx < TOP29) begin
        for (int k = 0; k < 3; k++) m[k] = m[k] << 1;
        mx = mx << 1;
      end
  endfunction

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic void unit_vec(input longint v[3], input int frac, output longint o[3]);
    longint unsigned m[3], s, len, q;
    for (int k = 0; k < 3; k++) m[k] = mag(v[k]);
    o = '{0, 0, 0};
    if (max3(m) == 0) return;
    fit_mags(m, 1'b1);
    s = 0;
    for (int k = 0; k < 3; k++) s += m[k] * m[k];
    len = floor_sqrt(s);
    for (int k = 0; k < 3; k++) begin
      q = ((m[k] << frac) + (len >> 1)) / len;
      o[k] = v[k] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  // works out the ten inset records of one triangle and advances the counter
  function automatic void inset_triangle(tri_t t);
    longint p[3][3], ctr[3], e1[3], e2[3], cr[3], nrm[3], d[3], u[3], np;
    longint unsigned m1[3], m2[3], base, nv[3], amag, dm, vidx[6];
    bit aneg;
    rec_t r;
    int ring[7][3] = '{'{0, 1, 4}, '{0, 4, 3}, '{1, 2, 5}, '{1, 5, 4},
                       '{2, 0, 3}, '{2, 3, 5}, '{3, 4, 5}};
    amag = mag(inset_q);
    aneg = inset_q < 0;
    for (int v = 0; v < 3; v++)
      for (int k = 0; k < 3; k++) p[v][k] = longint'($signed(t.crd[v * 3 + k]));
    for (int k = 0; k < 3; k++) begin
      ctr[k] = p[0][k] + p[1][k] + p[2][k];
      m1[k] = mag(p[1][k] - p[0][k]);
      m2[k] = mag(p[2][k] - p[0][k]);
    end
    fit_mags(m1, 1'b0);
    fit_mags(m2, 1'b0);
    for (int k = 0; k < 3; k++) begin
      e1[k] = (p[1][k] - p[0][k] < 0) ? -longint'(m1[k]) : longint'(m1[k]);
      e2[k] = (p[2][k] - p[0][k] < 0) ? -longint'(m2[k]) : longint'(m2[k]);
    end
    cr[0] = e1[1] * e2[2] - e1[2] * e2[1];
    cr[1] = e1[2] * e2[0] - e1[0] * e2[2];
    cr[2] = e1[0] * e2[1] - e1[1] * e2[0];
    unit_vec(cr, 14, nrm);

    base = next_vtx & IDX_MASK;
    for (int k = 0; k < 3; k++) nv[k] = (base + k) & IDX_MASK;
    if (base + 3 > IDX_MASK) wrap_flag = 1'b1;
    next_vtx = (base + 3) & IDX_MASK;

    for (int v = 0; v < 3; v++) begin
      r = '{default: '0, pos: '{0, 0, 0}, nrm: '{0, 0, 0}, vix: '{0, 0, 0}};
      for (int k = 0; k < 3; k++) d[k] = ctr[k] - 3 * p[v][k];
      unit_vec(d, 30, u);
      for (int k = 0; k < 3; k++) begin
        dm = (amag * mag(u[k]) + TOP29) >> 30;
        np = p[v][k] + ((aneg != (u[k] < 0)) ? -longint'(dm) : longint'(dm));
        if (np > longint'(MAX_C)) np = MAX_C;
        if (np < longint'(MIN_C)) np = MIN_C;
        r.pos[k] = np[31:0];
        r.nrm[k] = nrm[k][15:0];
      end
      r.ovf = wrap_flag;
      pending_recs = {pending_recs, r};
    end
    for (int k = 0; k < 3; k++) begin
      vidx[k] = t.idx[k];
      vidx[k + 3] = nv[k];
    end
    for (int j = 0; j < 7; j++) begin
      r = '{default: '0, pos: '{0, 0, 0}, nrm: '{0, 0, 0}, vix: '{0, 0, 0}};
      r.kind = 1'b1;
      for (int k = 0; k < 3; k++) r.vix[k] = vidx[ring[j][k]][23:0];
      r.ovf = wrap_flag;
      r.last = (j == 6);
      pending_recs = {pending_recs, r};
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  function automatic logic [mfi_pkg::IN_W-1:0] pack_tri(tri_t t);
    logic [mfi_pkg::IN_W-1:0] w;
    for (int i = 0; i < 9; i++) w[i * 32 +: 32] = t.crd[i];
    for (int i = 0; i < 3; i++) w[288 + i * 24 +: 24] = t.idx[i];
    return w;
  endfunction

  function automatic tri_t make_tri(int a[3], int b[3], int c[3], logic [23:0] ia,
                                    logic [23:0] ib, logic [23:0] ic);
    tri_t t;
    for (int k = 0; k < 3; k++) begin
      t.crd[k] = a[k];
      t.crd[3 + k] = b[k];
      t.crd[6 + k] = c[k];
    end
    t.idx = '{ia, ib, ic};
    return t;
  endfunction

  // offers one triangle, waits for the handshake, then queues its records
  task automatic send_tri(tri_t t, bit known, logic [15:0] nrm[3]);
    int first;
    while (idle_on && $urandom_range(99) < 29) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= pack_tri(t);
    do @(posedge clk); while (!s_tready);
    first = pending_recs.size();
    inset_triangle(t);
    // typed expectation: corners stay put, normal read off the geometry
    if (known)
      for (int v = 0; v < 3; v++)
        for (int k = 0; k < 3; k++) begin
          pending_recs[first + v].pos[k] = t.crd[v * 3 + k];
          pending_recs[first + v].nrm[k] = nrm[k];
        end
  endtask

  // register write only with the block drained and quiet
  task automatic write_reg(logic [mfi_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
    s_tvalid <= 1'b0;
    while (pending_recs.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == mfi_pkg::REG_INSET) begin
      inset_q = longint'($signed(val));
    end else begin
      next_vtx = val[23:0];
      wrap_flag = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------- receiver

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (want_hold && !hold_done) begin
      // long stall: the block fills its output and stops taking requests
      hold_done <= 1'b1;
      hold_left <= 3000;
      m_tready <= 1'b0;
    end else begin
      m_tready <= idle_on ? ($urandom_range(99) >= 29) : 1'b1;
    end
  end

  // record checker: every accepted record against the oldest expectation
  always @(posedge clk) begin
    rec_t e;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_recs.size() == 0) begin
        $error("unexpected record %h", m_tdata);
        errors++;
      end else begin
        e = pending_recs.pop_front();
        if (m_tuser !== e.kind) begin
          $error("kind exp %0d got %0d", e.kind, m_tuser); errors++;
        end
        for (int k = 0; k < 3; k++) begin
          if (m_tdata[k * 32 +: 32] !== e.pos[k]) begin
            $error("pos[%0d] exp %h got %h", k, e.pos[k], m_tdata[k * 32 +: 32]);
            errors++;
          end
          if (m_tdata[96 + k * 16 +: 16] !== e.nrm[k]) begin
            $error("norm[%0d] exp %h got %h", k, e.nrm[k], m_tdata[96 + k * 16 +: 16]);
            errors++;
          end
          if (m_tdata[144 + k * 24 +: 24] !== e.vix[k]) begin
            $error("tri[%0d] exp %h got %h", k, e.vix[k], m_tdata[144 + k * 24 +: 24]);
            errors++;
          end
        end
        if (m_tdata[216] !== e.ovf) begin
          $error("overflow exp %0d got %0d", e.ovf, m_tdata[216]); errors++;
        end
        if (m_tlast !== e.last) begin
          $error("last exp %0d got %0d", e.last, m_tlast); errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- stimulus

  function automatic int rnd_coord(int mode);
    case (mode)
      0: return $urandom();
      1: return $signed($urandom_range(2 * (1 << 20))) - (1 << 20);
      default: case ($urandom_range(3))
        0: return MAX_C;
        1: return MIN_C;
        2: return 0;
        default: return $urandom();
      endcase
    endcase
  endfunction

  function automatic tri_t rnd_tri();
    int a[3], b[3], c[3], mode, sel;
    logic [23:0] ix[3];
    sel = $urandom_range(9);
    mode = sel < 4 ? 0 : (sel < 7 ? 1 : 2);
    for (int k = 0; k < 3; k++) begin
      a[k] = rnd_coord(mode);
      b[k] = rnd_coord(mode);
      c[k] = rnd_coord(mode);
      ix[k] = ($urandom_range(7) == 0) ? 24'hFF_FFFF : 24'($urandom());
    end
    if (sel == 7) begin  // all corners coincide
      b = a;
      c = a;
    end else if (sel == 8) begin  // collinear corners
      for (int k = 0; k < 3; k++) begin
        a[k] = a[k] >>> 2;
        b[k] = b[k] >>> 2;
        c[k] = 2 * b[k] - a[k];
      end
    end
    return make_tri(a, b, c, ix[0], ix[1], ix[2]);
  endfunction

  function automatic void add_row(logic [1:0] sw, logic [31:0] sv, tri_t t, bit known,
                                  logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
    row_t r;
    r.set_what = sw;
    r.set_val = sv;
    r.t = t;
    r.known = known;
    r.nrm = '{nx, ny, nz};
    rows = {rows, r};
  endfunction

  initial begin
    int z[3], ex[3], ey[3], ez[3], hi[3], lo[3], mix[3];
    logic [15:0] no_n[3];
    logic [31:0] ins;
    z = '{0, 0, 0};
    ex = '{ONE, 0, 0};
    ey = '{0, ONE, 0};
    ez = '{0, 0, ONE};
    hi = '{MAX_C, MAX_C, MAX_C};
    lo = '{MIN_C, MIN_C, MIN_C};
    mix = '{0, MAX_C, MIN_C};
    no_n = '{16'd0, 16'd0, 16'd0};
    inset_q = 0;
    next_vtx = 0;
    wrap_flag = 1'b0;

    // directed part, first with the reset configuration, then after register writes
    add_row(SET_NONE, 0, make_tri(z, z, z, 0, 0, 0), 1, 0, 0, 0);
    add_row(SET_NONE, 0, make_tri(z, ex, ey, 1, 2, 3), 1, 0, 0, 16384);
    add_row(SET_NONE, 0, make_tri(z, ey, ex, 4, 5, 6), 1, 0, 0, -16'sd16384);
    add_row(SET_NONE, 0, make_tri(z, ey, ez, 7, 8, 9), 1, 16384, 0, 0);
    add_row(SET_NONE, 0, make_tri(hi, lo, mix, 24'hFF_FFFF, 24'hFF_FFFF, 24'hFF_FFFF),
            0, 0, 0, 0);
    add_row(SET_NONE, 0, make_tri(lo, lo, lo, 10, 11, 12), 1, 0, 0, 0);
    add_row(SET_INSET, ONE, make_tri(z, ex, ey, 13, 14, 15), 0, 0, 0, 0);
    add_row(SET_NONE, 0, make_tri(hi, hi, hi, 16, 17, 18), 1, 0, 0, 0);
    add_row(SET_INSET, MAX_C, make_tri(hi, lo, mix, 19, 20, 21), 0, 0, 0, 0);
    add_row(SET_NONE, 0, make_tri(lo, hi, z, 22, 23, 24), 0, 0, 0, 0);
    add_row(SET_INSET, MIN_C, make_tri(hi, lo, mix, 25, 26, 27), 0, 0, 0, 0);
    add_row(SET_NONE, 0, make_tri(z, ex, ez, 28, 29, 30), 0, 0, 0, 0);
    // counter runs past the index range, then stays flagged
    add_row(SET_START, 24'hFF_FFFD, make_tri(z, ex, ey, 31, 32, 33), 0, 0, 0, 0);
    add_row(SET_NONE, 0, make_tri(z, ey, ez, 34, 35, 36), 0, 0, 0, 0);
    add_row(SET_START, 24'hFF_FFFE, make_tri(ex, ey, ez, 37, 38, 39), 0, 0, 0, 0);
    // reload clears the flag
    add_row(SET_START, 5, make_tri(ex, ez, ey, 40, 41, 42), 0, 0, 0, 0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      if (rows[i].set_what == SET_INSET) write_reg(mfi_pkg::REG_INSET, rows[i].set_val);
      else if (rows[i].set_what == SET_START) write_reg(mfi_pkg::REG_START, rows[i].set_val);
      send_tri(rows[i].t, rows[i].known, rows[i].nrm);
    end

    // random part: eight phases of about forty triangles, registers
    // rewritten between phases with the pipe drained
    for (int ph = 0; ph < 8; ph++) begin
      case ($urandom_range(4))
        0: ins = $urandom();
        1: ins = 0;
        2: ins = ($urandom_range(1) ? MAX_C : MIN_C);
        default: ins = ($signed($urandom_range(16)) - 8) * ONE + $urandom_range(ONE - 1);
      endcase
      write_reg(mfi_pkg::REG_INSET, ins);
      write_reg(mfi_pkg::REG_START, $urandom_range(1) ? 24'hFF_FFFF - $urandom_range(60)
                                                      : 24'($urandom()));
      if (ph == 1) want_hold = 1'b1;
      for (int i = 0; i < 41; i++) begin
        idle_on = !(ph == 3);  // one phase at full rate on both sides
        send_tri(rnd_tri(), 0, no_n);
      end
    end
    idle_on = 1'b1;
    s_tvalid <= 1'b0;

    while (pending_recs.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  // watchdog
  initial begin
    #30ms;
    $display("simulation failed");
    $finish;
  end

endmodule
